FILE: src/lrf_pkg.sv
// lrf_pkg: widths, command codes, micro-op codes and the control store of the ramp fader
// no dependencies; imported by linear_ramp_fader

package lrf_pkg;

   localparam int LEVEL_W   = 32;
   localparam int TICK_W    = 16;
   localparam int DUR_W     = 16;
   localparam int SLOPE_W   = 48;
   localparam int ELAPSED_W = 17;
   localparam int PROD_W    = SLOPE_W + TICK_W;
   localparam int FRAC_W    = 16;
   localparam int HALF_W    = SLOPE_W / 2;

   localparam logic [DUR_W-1:0] DURATION_RESET = DUR_W'(1000);

   // one quotient bit per divide step
   localparam int DIV_STEPS = SLOPE_W;
   localparam int COUNT_W   = $clog2(DIV_STEPS);

   localparam logic [SLOPE_W-1:0] SLOPE_MAX = {1'b0, {(SLOPE_W-1){1'b1}}};
   localparam logic [SLOPE_W-1:0] SLOPE_MIN = {1'b1, {(SLOPE_W-1){1'b0}}};
   localparam logic [LEVEL_W-1:0] LEVEL_MAX = {1'b0, {(LEVEL_W-1){1'b1}}};
   localparam logic [LEVEL_W-1:0] LEVEL_MIN = {1'b1, {(LEVEL_W-1){1'b0}}};

   typedef enum logic [1:0] {
      CMD_TICK   = 2'd0,
      CMD_SET    = 2'd1,
      CMD_RAMP   = 2'd2,
      CMD_UNUSED = 2'd3
   } command_type;

   localparam int ADDR_W = 4;
   typedef logic [ADDR_W-1:0] addr_type;

   localparam addr_type ADDR_WAIT     = 4'd0;
   localparam addr_type ADDR_SET      = 4'd1;
   localparam addr_type ADDR_RT_INIT  = 4'd2;
   localparam addr_type ADDR_DIV      = 4'd3;
   localparam addr_type ADDR_RT_DONE  = 4'd4;
   localparam addr_type ADDR_TK_CHECK = 4'd5;
   localparam addr_type ADDR_MUL_LO   = 4'd6;
   localparam addr_type ADDR_MUL_HI   = 4'd7;
   localparam addr_type ADDR_TK_DONE  = 4'd8;
   localparam addr_type ADDR_EMIT     = 4'd9;

   typedef enum logic [3:0] {
      UOP_WAIT,
      UOP_SET,
      UOP_RT_INIT,
      UOP_DIV,
      UOP_RT_DONE,
      UOP_TK_CHECK,
      UOP_MUL_LO,
      UOP_MUL_HI,
      UOP_TK_DONE,
      UOP_EMIT
   } uop_type;

   typedef enum logic [2:0] {
      JMP_NEXT,
      JMP_ALWAYS,
      JMP_DISPATCH,
      JMP_LOOP,
      JMP_TICK_SKIP,
      JMP_EMIT_WAIT
   } jump_type;

   typedef struct packed {
      uop_type  uop;
      jump_type jump;
      addr_type target;
   } ctrl_word_type;

   // control store
   function automatic ctrl_word_type ucode_rom(addr_type addr);
      ctrl_word_type w;
      unique case (addr)
         ADDR_WAIT:     w = '{UOP_WAIT,     JMP_DISPATCH,  ADDR_WAIT};
         ADDR_SET:      w = '{UOP_SET,      JMP_ALWAYS,    ADDR_EMIT};
         ADDR_RT_INIT:  w = '{UOP_RT_INIT,  JMP_NEXT,      ADDR_WAIT};
         ADDR_DIV:      w = '{UOP_DIV,      JMP_LOOP,      ADDR_DIV};
         ADDR_RT_DONE:  w = '{UOP_RT_DONE,  JMP_ALWAYS,    ADDR_EMIT};
         ADDR_TK_CHECK: w = '{UOP_TK_CHECK, JMP_TICK_SKIP, ADDR_EMIT};
         ADDR_MUL_LO:   w = '{UOP_MUL_LO,   JMP_NEXT,      ADDR_WAIT};
         ADDR_MUL_HI:   w = '{UOP_MUL_HI,   JMP_NEXT,      ADDR_WAIT};
         ADDR_TK_DONE:  w = '{UOP_TK_DONE,  JMP_NEXT,      ADDR_WAIT};
         ADDR_EMIT:     w = '{UOP_EMIT,     JMP_EMIT_WAIT, ADDR_WAIT};
         default:       w = '{UOP_WAIT,     JMP_ALWAYS,    ADDR_WAIT};
      endcase
      return w;
   endfunction

   // entry point of each command's routine
   function automatic addr_type dispatch(command_type cmd);
      addr_type a;
      unique case (cmd)
         CMD_TICK:   a = ADDR_TK_CHECK;
         CMD_SET:    a = ADDR_SET;
         CMD_RAMP:   a = ADDR_RT_INIT;
         CMD_UNUSED: a = ADDR_EMIT;
         default:    a = ADDR_EMIT;
      endcase
      return a;
   endfunction

endpackage

FILE: src/linear_ramp_fader.sv
// linear_ramp_fader: top level, microcoded sequencer with divider, multiplier and output register
// depends on lrf_pkg (widths, codes, control store)

// Linear ramp fader. Holds a signed Q16.16 level that moves in a straight
// line toward a target. Commands: set (level and target loaded at once, ramp
// ends), ramp (new target, slope = (target - level) / ramp_duration in signed
// Q16.32, truncated toward zero and saturated), tick (advance a running ramp
// by tick_count ticks; the level snaps to the target once the elapsed count
// reaches ramp_duration, else moves by slope * ticks, truncated toward zero
// and saturated to 32 bits). Every request beat gives one response beat with
// the level and the ramping flag after that command. Command code 3 leaves
// everything unchanged. Control runs from a ten-word control store; one word
// per cycle, with a step counter and conditional jumps. Set runs set and emit;
// unused code 3 goes straight to emit; a tick that ends or finds no ramp runs
// check and emit; a tick that moves the level runs check, two 24x16 partial
// products, sum and emit; a ramp runs init, the 48-step restoring divider that
// yields one quotient bit a cycle, done and emit. The response beat appears
// the cycle after the last step; if the previous response is still stalled,
// the sequencer waits in its final step. ramp_duration is written through the
// csr port only while the sequencer waits for a request; a write also clears
// the elapsed tick count. Reset value of ramp_duration is 1000.

module linear_ramp_fader (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_command,
   input  logic signed [lrf_pkg::LEVEL_W-1:0] req_new_value,
   input  logic [lrf_pkg::TICK_W-1:0]    req_tick_count,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [lrf_pkg::LEVEL_W-1:0] rsp_current_level,
   output logic                          rsp_in_transition,
   // configuration write channel
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [lrf_pkg::DUR_W-1:0]     csr_ramp_duration
);
   import lrf_pkg::*;

   // sequencer
   addr_type      pc_ff, pc_in;
   ctrl_word_type ctrl;

   // architectural state
   logic [LEVEL_W-1:0]   level_ff, level_in;
   logic [LEVEL_W-1:0]   target_ff, target_in;
   logic [SLOPE_W-1:0]   slope_ff, slope_in;
   logic [ELAPSED_W-1:0] elapsed_ff, elapsed_in;
   logic                 ramping_ff, ramping_in;
   logic [DUR_W-1:0]     dur_ff, dur_in;

   // latched request beat
   logic [LEVEL_W-1:0]   nv_ff, nv_in;
   logic [TICK_W-1:0]    ticks_ff, ticks_in;

   // working registers of divider and multiplier
   logic [SLOPE_W-1:0]   dvd_ff, dvd_in;     // dividend shifting out, quotient shifting in
   logic [DUR_W-1:0]     rem_ff, rem_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic                 neg_ff, neg_in;     // sign of the slope being computed or applied
   logic [SLOPE_W-1:0]   smag_ff, smag_in;   // slope magnitude for the tick product
   logic [PROD_W-1:0]    prod_ff, prod_in;

   // response register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [LEVEL_W-1:0]   rsp_level_ff, rsp_level_in;
   logic                 rsp_trans_ff, rsp_trans_in;

   // handshakes
   logic req_fire, csr_fire, out_free;

   // datapath intermediates
   logic [LEVEL_W:0]       diff;
   logic [LEVEL_W:0]       diff_mag;
   logic [DUR_W:0]         trial;
   logic                   trial_ge;
   logic [ELAPSED_W-1:0]   elapsed_sum;
   logic                   snap;
   logic [HALF_W+TICK_W-1:0] pp_lo, pp_hi;
   logic [SLOPE_W-1:0]     step_mag;
   logic [SLOPE_W+1:0]     level_ext, level_sum;
   logic                   sum_fits;

   assign ctrl = ucode_rom(pc_ff);

   // stall everything but the wait step
   assign req_stall = (ctrl.uop != UOP_WAIT);
   assign csr_ready = (ctrl.uop == UOP_WAIT);
   assign req_fire  = req_valid && !req_stall;
   assign csr_fire  = csr_valid && csr_ready;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_current_level = rsp_level_ff;
   assign rsp_in_transition = rsp_trans_ff;

   // ramp setup: magnitude of (target - level)
   assign diff     = {nv_ff[LEVEL_W-1], nv_ff} - {level_ff[LEVEL_W-1], level_ff};
   assign diff_mag = diff[LEVEL_W] ? (~diff + 1'b1) : diff;

   // one restoring divide step
   assign trial    = {rem_ff, dvd_ff[SLOPE_W-1]};
   assign trial_ge = (trial >= {1'b0, dur_ff});

   // tick advance
   assign elapsed_sum = elapsed_ff + {{(ELAPSED_W-TICK_W){1'b0}}, ticks_ff};
   assign snap        = (elapsed_sum >= {{(ELAPSED_W-DUR_W){1'b0}}, dur_ff});

   // two 24x16 partial products
   assign pp_lo = smag_ff[HALF_W-1:0] * ticks_ff;
   assign pp_hi = smag_ff[SLOPE_W-1:HALF_W] * ticks_ff;

   // level + or - truncated step, checked against the 32-bit range
   assign step_mag  = prod_ff[PROD_W-1:FRAC_W];
   assign level_ext = {{(SLOPE_W+2-LEVEL_W){level_ff[LEVEL_W-1]}}, level_ff};
   assign level_sum = neg_ff ? (level_ext - {2'b00, step_mag})
                             : (level_ext + {2'b00, step_mag});
   assign sum_fits  = (level_sum[SLOPE_W+1:LEVEL_W-1] ==
                       {(SLOPE_W+3-LEVEL_W){level_sum[SLOPE_W+1]}});

   // next address
   always_comb begin
      pc_in = pc_ff + 1'b1;
      unique case (ctrl.jump)
         JMP_NEXT:      pc_in = pc_ff + 1'b1;
         JMP_ALWAYS:    pc_in = ctrl.target;
         JMP_DISPATCH:  pc_in = req_fire ? dispatch(command_type'(req_command)) : pc_ff;
         JMP_LOOP:      pc_in = (count_ff != '0) ? ctrl.target : pc_ff + 1'b1;
         JMP_TICK_SKIP: pc_in = (!ramping_ff || snap) ? ctrl.target : pc_ff + 1'b1;
         JMP_EMIT_WAIT: pc_in = out_free ? ctrl.target : pc_ff;
         default:       pc_in = ADDR_WAIT;
      endcase
   end

   // datapath driven by the micro-op
   always_comb begin
      level_in     = level_ff;
      target_in    = target_ff;
      slope_in     = slope_ff;
      elapsed_in   = elapsed_ff;
      ramping_in   = ramping_ff;
      dur_in       = dur_ff;
      nv_in        = nv_ff;
      ticks_in     = ticks_ff;
      dvd_in       = dvd_ff;
      rem_in       = rem_ff;
      count_in     = count_ff;
      neg_in       = neg_ff;
      smag_in      = smag_ff;
      prod_in      = prod_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_level_in = rsp_level_ff;
      rsp_trans_in = rsp_trans_ff;

      unique case (ctrl.uop)
         UOP_WAIT: begin
            if (req_fire) begin
               nv_in    = req_new_value;
               ticks_in = req_tick_count;
            end
            if (csr_fire) begin
               dur_in     = csr_ramp_duration;
               elapsed_in = '0;
            end
         end
         UOP_SET: begin
            level_in   = nv_ff;
            target_in  = nv_ff;
            ramping_in = 1'b0;
         end
         UOP_RT_INIT: begin
            target_in  = nv_ff;
            ramping_in = 1'b1;
            elapsed_in = '0;
            neg_in     = diff[LEVEL_W];
            dvd_in     = {diff_mag[LEVEL_W-1:0], {FRAC_W{1'b0}}};
            rem_in     = '0;
            count_in   = COUNT_W'(DIV_STEPS - 1);
         end
         UOP_DIV: begin
            rem_in   = trial_ge ? DUR_W'(trial - {1'b0, dur_ff}) : trial[DUR_W-1:0];
            dvd_in   = {dvd_ff[SLOPE_W-2:0], trial_ge};
            count_in = count_ff - 1'b1;
         end
         UOP_RT_DONE: begin
            if (dur_ff == '0) begin
               slope_in = '0;
            end else if (!neg_ff) begin
               slope_in = dvd_ff[SLOPE_W-1] ? SLOPE_MAX : dvd_ff;
            end else begin
               // a magnitude of 2^47 or more lands on the most negative slope
               slope_in = dvd_ff[SLOPE_W-1] ? SLOPE_MIN : (~dvd_ff + 1'b1);
            end
         end
         UOP_TK_CHECK: begin
            if (ramping_ff) begin
               if (snap) begin
                  ramping_in = 1'b0;
                  level_in   = target_ff;
                  elapsed_in = '0;
               end else begin
                  elapsed_in = elapsed_sum;
               end
            end
            neg_in  = slope_ff[SLOPE_W-1];
            smag_in = slope_ff[SLOPE_W-1] ? (~slope_ff + 1'b1) : slope_ff;
         end
         UOP_MUL_LO: begin
            prod_in = {{(PROD_W-HALF_W-TICK_W){1'b0}}, pp_lo};
         end
         UOP_MUL_HI: begin
            prod_in = prod_ff + {pp_hi, {HALF_W{1'b0}}};
         end
         UOP_TK_DONE: begin
            if (sum_fits) begin
               level_in = level_sum[LEVEL_W-1:0];
            end else begin
               level_in = level_sum[SLOPE_W+1] ? LEVEL_MIN : LEVEL_MAX;
            end
         end
         UOP_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_level_in = level_ff;
               rsp_trans_in = ramping_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= ADDR_WAIT;
         rsp_valid_ff <= 1'b0;
         level_ff     <= '0;
         target_ff    <= '0;
         slope_ff     <= '0;
         elapsed_ff   <= '0;
         ramping_ff   <= 1'b0;
         dur_ff       <= DURATION_RESET;
      end else begin
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
         level_ff     <= level_in;
         target_ff    <= target_in;
         slope_ff     <= slope_in;
         elapsed_ff   <= elapsed_in;
         ramping_ff   <= ramping_in;
         dur_ff       <= dur_in;
      end
   end

   // payload and working registers
   always_ff @(posedge clock) begin
      nv_ff        <= nv_in;
      ticks_ff     <= ticks_in;
      dvd_ff       <= dvd_in;
      rem_ff       <= rem_in;
      count_ff     <= count_in;
      neg_ff       <= neg_in;
      smag_ff      <= smag_in;
      prod_ff      <= prod_in;
      rsp_level_ff <= rsp_level_in;
      rsp_trans_ff <= rsp_trans_in;
   end

   // a ramp beat starts the ramp routine
   a_ramp_dispatch: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_command == CMD_RAMP) |=> (pc_ff == ADDR_RT_INIT))
      else $error("ramp beat did not enter ramp routine");

   // the divider stays in its loop and counts down
   a_div_count: assert property (@(posedge clock) disable iff (reset)
      (ctrl.uop == UOP_DIV && count_ff != '0) |=>
         (ctrl.uop == UOP_DIV && count_ff == $past(count_ff) - 1'b1))
      else $error("divider loop count broken");

   // partial remainder stays below the divisor
   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      (ctrl.uop == UOP_DIV && dur_ff != '0) |-> (rem_ff < dur_ff))
      else $error("divider remainder out of range");

   // while a ramp runs, the elapsed count is below the duration between commands
   a_elapsed_range: assert property (@(posedge clock) disable iff (reset)
      (ctrl.uop == UOP_WAIT && ramping_ff && dur_ff != '0) |->
         (elapsed_ff < {{(ELAPSED_W-DUR_W){1'b0}}, dur_ff}))
      else $error("elapsed count reached duration while ramping");

   // a new response beat only comes out of the emit step
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(ctrl.uop == UOP_EMIT))
      else $error("response beat raised outside emit step");

endmodule

FILE: verif/linear_ramp_fader_tb.sv
// linear_ramp_fader_tb: self-checking bench for the ramp fader (set, retarget, tick and unused commands)
// depends on lrf_pkg and linear_ramp_fader; drives random bursts and random response stalls
// and checks every response beat against an in-bench model of the fader

module linear_ramp_fader_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lrf_pkg::*;

   localparam int IDLE_LIMIT   = 4000;   // cycles with no handshake before giving up
   localparam int TAIL_CYCLES  = 60;     // longer than the slowest command (ramp divide)
   localparam int TOTAL_BEATS  = 1110;
   localparam int PHASE_BEATS  = 80;

   localparam longint SLOPE_HI = (longint'(1) <<< 47) - 1;
   localparam longint SLOPE_LO = -(longint'(1) <<< 47);
   localparam longint LEVEL_HI = (longint'(1) <<< 31) - 1;
   localparam longint LEVEL_LO = -(longint'(1) <<< 31);

   typedef struct packed {
      logic [LEVEL_W-1:0] level;
      logic               ramping;
   } fader_out_type;

   typedef enum int {STALL_NONE, STALL_SCATTER, STALL_RUNS} stall_mode_type;

   // dut ports; the inputs are known from time zero
   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic [1:0]                 req_command = CMD_TICK;
   logic signed [LEVEL_W-1:0]  req_new_value = '0;
   logic [TICK_W-1:0]          req_tick_count = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic signed [LEVEL_W-1:0]  rsp_current_level;
   logic                       rsp_in_transition;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [DUR_W-1:0]           csr_ramp_duration = DURATION_RESET;

   // fader model state, mirrors the block after each accepted beat
   logic signed [LEVEL_W-1:0]  model_level    = '0;
   logic signed [LEVEL_W-1:0]  model_target   = '0;
   logic signed [SLOPE_W-1:0]  model_slope    = '0;
   logic [ELAPSED_W-1:0]       model_elapsed  = '0;
   logic                       model_ramping  = 1'b0;
   logic [DUR_W-1:0]           model_duration = DURATION_RESET;

   // levels the block still owes us, oldest first
   fader_out_type levels_due[$];
   fader_out_type level_seen;

   int failures    = 0;
   int beats_sent  = 0;
   int burst_left  = 0;
   int idle_cycles = 0;

   stall_mode_type stall_mode = STALL_NONE;
   int             mode_left  = 0;
   int             run_left   = 0;

   linear_ramp_fader dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_command       (req_command),
      .req_new_value     (req_new_value),
      .req_tick_count    (req_tick_count),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_current_level (rsp_current_level),
      .rsp_in_transition (rsp_in_transition),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_ramp_duration (csr_ramp_duration)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // synchronous reset, released only here
   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
   end

   function automatic longint clamp(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   // advance the fader model by one command and queue the level it should report
   function automatic void step_fader(command_type cmd, logic signed [LEVEL_W-1:0] value,
                                      logic [TICK_W-1:0] ticks);
      longint diff_q32;
      longint move_q16;
      case (cmd)
         CMD_SET: begin
            model_level   = value;
            model_target  = value;
            model_ramping = 1'b0;
         end
         CMD_RAMP: begin
            model_target  = value;
            model_ramping = 1'b1;
            model_elapsed = '0;
            if (model_duration == '0) begin
               model_slope = '0;
            end else begin
               // exact difference in Q16.32, truncated toward zero by the signed divide
               diff_q32 = (longint'(value) - longint'(model_level)) * 65536;
               model_slope = SLOPE_W'(clamp(diff_q32 / longint'(model_duration),
                                            SLOPE_LO, SLOPE_HI));
            end
         end
         CMD_TICK: begin
            if (model_ramping) begin
               model_elapsed = model_elapsed + ELAPSED_W'(ticks);
               if (model_elapsed >= ELAPSED_W'(model_duration)) begin
                  // ramp is over: snap onto the target
                  model_ramping = 1'b0;
                  model_level   = model_target;
                  model_elapsed = '0;
               end else begin
                  // Q16.32 times ticks, back to Q16.16 rounding toward zero
                  move_q16 = longint'(model_slope) * longint'(ticks);
                  move_q16 = (move_q16 < 0) ? -((-move_q16) >>> 16) : (move_q16 >>> 16);
                  model_level = LEVEL_W'(clamp(longint'(model_level) + move_q16,
                                               LEVEL_LO, LEVEL_HI));
               end
            end
         end
         default: ;   // unused code: nothing moves
      endcase
      levels_due.push_back('{model_level, model_ramping});
   endfunction

   // one request beat; bursts of random length separated by random gaps
   task automatic send_beat(command_type cmd, logic [LEVEL_W-1:0] value,
                            logic [TICK_W-1:0] ticks);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 20)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 12);
      end
      req_valid      <= 1'b1;
      req_command    <= cmd;
      req_new_value  <= value;
      req_tick_count <= ticks;
      do @(posedge clock); while (req_stall);
      step_fader(cmd, value, ticks);
      burst_left--;
      beats_sent++;
   endtask

   // stop sending and wait until every owed response beat has come back
   task automatic drain_fader();
      req_valid  <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (levels_due.size() != 0);
   endtask

   // duration write, only with the sequencer idle; the write also clears elapsed
   task automatic write_ramp_duration(logic [DUR_W-1:0] duration);
      drain_fader();
      csr_valid         <= 1'b1;
      csr_ramp_duration <= duration;
      do @(posedge clock); while (!csr_ready);
      csr_valid      <= 1'b0;
      model_duration = duration;
      model_elapsed  = '0;
   endtask

   function automatic logic [LEVEL_W-1:0] pick_level();
      case ($urandom_range(0, 5))
         0:       return LEVEL_MAX;
         1:       return LEVEL_MIN;
         2:       return LEVEL_W'($urandom_range(0, 1 << 20)) - 32'h0008_0000;
         default: return $urandom;
      endcase
   endfunction

   // tick sizes scaled to the duration so most ramps finish in a handful of ticks
   function automatic logic [TICK_W-1:0] pick_ticks();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return 16'd1;
         2:       return 16'($urandom);
         3:       return model_duration - model_elapsed[DUR_W-1:0];
         default: return 16'($urandom_range(1, model_duration / 3 + 1));
      endcase
   endfunction

   function automatic logic [DUR_W-1:0] pick_duration(int phase);
      case (phase % 7)
         0:       return 16'd1;
         1:       return 16'hffff;
         2:       return 16'd1000;
         3:       return 16'd2;
         4:       return 16'($urandom_range(1, 16));
         5:       return 16'($urandom_range(17, 4096));
         default: return 16'($urandom_range(1, 65535));
      endcase
   endfunction

   // reset duration of 1000 still in force: idle ticks, unused code, extreme sets
   task automatic test_hold_and_unused();
      send_beat(CMD_TICK, $urandom, 16'hffff);
      send_beat(CMD_UNUSED, $urandom, 16'($urandom));
      send_beat(CMD_SET, LEVEL_MAX, '0);
      send_beat(CMD_SET, LEVEL_MIN, 16'hffff);
   endtask

   // full ramp that lands exactly on the duration, then a ramp to the level already held
   task automatic test_ramp_completion();
      send_beat(CMD_RAMP, 32'h0064_0000, '0);
      send_beat(CMD_TICK, '0, 16'd300);
      send_beat(CMD_TICK, '0, 16'd300);
      send_beat(CMD_TICK, '0, 16'd400);
      send_beat(CMD_RAMP, model_level, '0);
      send_beat(CMD_TICK, '0, 16'd999);
      send_beat(CMD_TICK, '0, 16'd1);
   endtask

   // duration 1 lets the slope hit both ends of its 48-bit range
   task automatic test_slope_saturation();
      write_ramp_duration(16'd1);
      send_beat(CMD_SET, LEVEL_MIN, '0);
      send_beat(CMD_RAMP, LEVEL_MAX, '0);
      send_beat(CMD_TICK, '0, '0);
      send_beat(CMD_TICK, '0, 16'd1);
      send_beat(CMD_RAMP, LEVEL_MIN, '0);
      send_beat(CMD_TICK, '0, 16'hffff);
   endtask

   // steep slope kept while the duration grows, so the level runs into its clamp
   task automatic test_level_saturation();
      write_ramp_duration(16'd2);
      send_beat(CMD_SET, '0, '0);
      send_beat(CMD_RAMP, LEVEL_MAX, '0);
      send_beat(CMD_TICK, '0, 16'd1);
      write_ramp_duration(16'hffff);
      send_beat(CMD_TICK, '0, 16'd65534);
      send_beat(CMD_TICK, '0, 16'd1);
      write_ramp_duration(16'd2);
      send_beat(CMD_SET, '0, '0);
      send_beat(CMD_RAMP, LEVEL_MIN, '0);
      send_beat(CMD_TICK, '0, 16'd1);
      write_ramp_duration(16'hffff);
      send_beat(CMD_TICK, '0, 16'd65534);
   endtask

   // phases at different durations; mostly set/ramp/tick runs, some raw noise
   task automatic test_random_traffic();
      int phase;
      int phase_end;
      int ticks_run;
      phase = 0;
      while (beats_sent < TOTAL_BEATS) begin
         write_ramp_duration(pick_duration(phase));
         phase++;
         phase_end = beats_sent + PHASE_BEATS;
         while (beats_sent < phase_end) begin
            if ($urandom_range(0, 4) == 0) begin
               send_beat(command_type'($urandom_range(0, 3)), $urandom, 16'($urandom));
            end else begin
               // without a set first, the ramp retargets from wherever the level is
               if ($urandom_range(0, 1) == 0) send_beat(CMD_SET, pick_level(), 16'($urandom));
               send_beat(CMD_RAMP, pick_level(), 16'($urandom));
               ticks_run = 0;
               while (model_ramping && ticks_run < 12) begin
                  send_beat(CMD_TICK, $urandom, pick_ticks());
                  ticks_run++;
               end
            end
         end
      end
   endtask

   // receiver stall pattern: quiet stretches, scattered stalls, long stall runs
   always @(posedge clock) begin
      if (mode_left == 0) begin
         stall_mode <= stall_mode_type'($urandom_range(0, 2));
         mode_left  <= $urandom_range(100, 400);
      end else begin
         mode_left <= mode_left - 1;
      end
      case (stall_mode)
         STALL_NONE:    rsp_stall <= 1'b0;
         STALL_SCATTER: rsp_stall <= ($urandom_range(0, 2) == 0);
         default: begin
            if (run_left == 0) begin
               rsp_stall <= ~rsp_stall;
               run_left  <= $urandom_range(1, 30);
            end else begin
               run_left <= run_left - 1;
            end
         end
      endcase
   end

   // response check: every accepted beat against the oldest owed level
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (levels_due.size() == 0) begin
            failures++;
            $display("%0t: unexpected beat, expected none, actual level %h transition %b",
                     $realtime, rsp_current_level, rsp_in_transition);
         end else begin
            level_seen = levels_due.pop_front();
            if (rsp_current_level !== level_seen.level) begin
               failures++;
               $display("%0t: current_level expected %h actual %h",
                        $realtime, level_seen.level, rsp_current_level);
            end
            if (rsp_in_transition !== level_seen.ramping) begin
               failures++;
               $display("%0t: in_transition expected %b actual %b",
                        $realtime, level_seen.ramping, rsp_in_transition);
            end
         end
      end
   end

   // watchdog: any handshake on any channel counts as progress
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("linear_ramp_fader_tb failed");
         $finish;
      end
   end

   initial begin
      do @(posedge clock); while (reset);
      test_hold_and_unused();
      test_ramp_completion();
      test_slope_saturation();
      test_level_saturation();
      test_random_traffic();
      drain_fader();
      // let any stray beat show up before the verdict
      repeat (TAIL_CYCLES) @(posedge clock);
      if (failures == 0)
         $display("linear_ramp_fader_tb passed");
      else
         $display("linear_ramp_fader_tb failed");
      $finish;
   end

endmodule

FILE: filelist.f
src/lrf_pkg.sv
src/linear_ramp_fader.sv
verif/linear_ramp_fader_tb.sv
